FILE: src/multi_channel_tick_dispatcher_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tick dispatcher core
// Concurrent assertions clocked and reset per use; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_TICK_DISPATCHER_CORE_MACROS_SVH
`define MULTI_CHANNEL_TICK_DISPATCHER_CORE_MACROS_SVH

`ifndef SYNTH
`define MCTD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define MCTD_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
`else
`define MCTD_ASSERT(lbl, clk, rstn, prop, msg)
`define MCTD_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

FILE: src/mctd_pkg.sv
// ----------------------------------------------------------------------------
// mctd_pkg
// Types and constants shared by the tick dispatcher controller and datapath.
// ----------------------------------------------------------------------------
package mctd_pkg;

  localparam int CHANNELS_DEF   = 8;
  localparam int COUNT_BITS_DEF = 32;

  localparam int OP_W    = 2;
  localparam int INDEX_W = 8;
  localparam int DATA_W  = 32;
  localparam int MASK_W  = 8;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 2'd0,
    OP_SET    = 2'd1,
    OP_RELOAD = 2'd2,
    OP_CLEAR  = 2'd3
  } mctd_op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } mctd_state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic execute;
  } mctd_cmd_t;

endpackage

FILE: src/mctd_ctrl.sv
// ----------------------------------------------------------------------------
// mctd_ctrl
// Sequencer: captures a command word, runs the execute state, strobes done.
// ----------------------------------------------------------------------------
`include "multi_channel_tick_dispatcher_core_macros.svh"

module mctd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  output mctd_pkg::mctd_cmd_t cmd_o,
  output logic                done_o
);
  import mctd_pkg::*;

  mctd_state_e state_q, state_d;
  logic        done_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    busy          = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.capture = start;
      end
      ST_EXEC: begin
        cmd_o.execute = 1'b1;
        busy          = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd_o.execute;
    end
  end

  assign done_o = done_q;

  `MCTD_ASSERT(a_accept_busy, clk_i, rst_ni, start && !busy |=> busy, "accept did not raise busy")
  `MCTD_ASSERT(a_exec_done, clk_i, rst_ni, busy |=> done_o && !busy, "execute not followed by done")
  `MCTD_ASSERT_IMPL(a_done_src, clk_i, rst_ni, done_o, $past(cmd_o.execute), "stray done strobe")

endmodule

FILE: src/mctd_datapath.sv
// ----------------------------------------------------------------------------
// mctd_datapath
// Command word register, one timer lane per channel, result registers.
// ----------------------------------------------------------------------------
module mctd_datapath #(
  parameter int CHANNELS   = mctd_pkg::CHANNELS_DEF,
  parameter int COUNT_BITS = mctd_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mctd_pkg::mctd_cmd_t           cmd_i,
  input  logic [mctd_pkg::OP_W-1:0]     op_i,
  input  logic [mctd_pkg::INDEX_W-1:0]  index_i,
  input  logic [mctd_pkg::DATA_W-1:0]   count_value_i,
  input  logic [mctd_pkg::DATA_W-1:0]   reload_value_i,
  input  logic                          enable_i,
  output logic                          status_o,
  output logic [mctd_pkg::MASK_W-1:0]   fired_mask_o
);
  import mctd_pkg::*;

  mctd_op_e            op_q;
  logic [INDEX_W-1:0]  index_q;
  logic [DATA_W-1:0]   count_q;
  logic [DATA_W-1:0]   reload_q;
  logic                enable_q;

  logic [COUNT_BITS-1:0] cnt_q [CHANNELS];
  logic [COUNT_BITS-1:0] per_q [CHANNELS];
  logic [CHANNELS-1:0]   en_q;
  logic [CHANNELS-1:0]   fire;
  logic [MASK_W-1:0]     mask;
  logic                  in_range;

  logic                  status_q;
  logic [MASK_W-1:0]     fired_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q     <= mctd_op_e'(op_i);
      index_q  <= index_i;
      count_q  <= count_value_i;
      reload_q <= reload_value_i;
      enable_q <= enable_i;
    end
  end

  assign in_range = {1'b0, index_q} < (INDEX_W+1)'(CHANNELS);

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    logic                  hit;
    logic                  active;
    logic [COUNT_BITS-1:0] dec;
    logic [COUNT_BITS-1:0] cnt_d, per_d;
    logic                  en_d;

    assign hit    = index_q == INDEX_W'(c);
    assign active = en_q[c] && !((cnt_q[c] == '0) && (per_q[c] == '0));
    assign dec    = cnt_q[c] - COUNT_BITS'(1);

    always_comb begin
      cnt_d   = cnt_q[c];
      per_d   = per_q[c];
      en_d    = en_q[c];
      fire[c] = 1'b0;
      unique case (op_q)
        OP_TICK: begin
          if (active) begin
            if (dec == '0) begin
              cnt_d   = per_q[c];
              fire[c] = 1'b1;
            end else begin
              cnt_d = dec;
            end
          end
        end
        OP_SET: begin
          if (hit) begin
            cnt_d = COUNT_BITS'(count_q);
            per_d = COUNT_BITS'(reload_q);
            en_d  = enable_q;
          end
        end
        OP_RELOAD: begin
          if (hit) cnt_d = per_q[c];
        end
        OP_CLEAR: begin
          // only an enabled channel is torn down
          if (hit && en_q[c]) begin
            cnt_d = '0;
            per_d = '0;
            en_d  = 1'b0;
          end
        end
        default: cnt_d = cnt_q[c];
      endcase
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cnt_q[c] <= '0;
        per_q[c] <= '0;
        en_q[c]  <= 1'b0;
      end else if (cmd_i.execute) begin
        cnt_q[c] <= cnt_d;
        per_q[c] <= per_d;
        en_q[c]  <= en_d;
      end
    end
  end

  // report only the low channels
  for (genvar i = 0; i < MASK_W; i++) begin : g_mask
    if (i < CHANNELS) begin : g_on
      assign mask[i] = fire[i];
    end else begin : g_off
      assign mask[i] = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      status_q <= (op_q != OP_TICK) && !in_range;
      fired_q  <= mask;
    end
  end

  assign status_o     = status_q;
  assign fired_mask_o = fired_q;

endmodule

FILE: src/multi_channel_tick_dispatcher_core.sv
// ----------------------------------------------------------------------------
// multi_channel_tick_dispatcher_core
// Bank of down-counting periodic timers driven by tick/set/reload/clear words.
// ----------------------------------------------------------------------------
//   channel   handshake         payload
//   command   start / busy      op_i, index_i, count_value_i, reload_value_i,
//                               enable_i
//   result    done_o (strobe)   status_o, fired_mask_o
//
// A command word is captured, then executed in the EXEC state, in which
// every channel lane updates in parallel; done_o pulses the cycle after.
// busy is high only during execute, so a new word may start while done_o shows.
// Reset clears all counts, periods and enables; there is no clearing pass.
// The receiver cannot stall: each result is valid for one cycle only.
// ----------------------------------------------------------------------------
module multi_channel_tick_dispatcher_core #(
  parameter int CHANNELS   = mctd_pkg::CHANNELS_DEF,
  parameter int COUNT_BITS = mctd_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [mctd_pkg::OP_W-1:0]     op_i,
  input  logic [mctd_pkg::INDEX_W-1:0]  index_i,
  input  logic [mctd_pkg::DATA_W-1:0]   count_value_i,
  input  logic [mctd_pkg::DATA_W-1:0]   reload_value_i,
  input  logic                          enable_i,
  output logic                          done_o,
  output logic                          status_o,
  output logic [mctd_pkg::MASK_W-1:0]   fired_mask_o
);
  import mctd_pkg::*;

  mctd_cmd_t cmd;

  mctd_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd),
    .done_o (done_o)
  );

  mctd_datapath #(
    .CHANNELS   (CHANNELS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .op_i           (op_i),
    .index_i        (index_i),
    .count_value_i  (count_value_i),
    .reload_value_i (reload_value_i),
    .enable_i       (enable_i),
    .status_o       (status_o),
    .fired_mask_o   (fired_mask_o)
  );

endmodule

FILE: tb/multi_channel_tick_dispatcher_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_channel_tick_dispatcher_core_test
// Drives tick, set, reload and clear words into the timer bank, predicts the
// status and fired mask of every word, and checks each done strobe in order.
// ----------------------------------------------------------------------------
module multi_channel_tick_dispatcher_core_test;
  import mctd_pkg::*;

  localparam int NUM_CHAN  = CHANNELS_DEF;
  localparam int CNT_W     = COUNT_BITS_DEF;
  localparam int DIRECT_N  = 23;
  localparam int RANDOM_N  = 1930;
  localparam int CALM_TAIL = 350;

  typedef struct packed {
    logic              status;
    logic [MASK_W-1:0] fired;
  } timer_result_t;

  class tick_scoreboard;
    logic [CNT_W-1:0] chan_count[NUM_CHAN];
    logic [CNT_W-1:0] chan_period[NUM_CHAN];
    bit               chan_on[NUM_CHAN];
    timer_result_t    pending_results[$];
    int               fail_count;

    function new();
      for (int c = 0; c < NUM_CHAN; c++) begin
        chan_count[c]  = '0;
        chan_period[c] = '0;
        chan_on[c]     = 1'b0;
      end
      fail_count = 0;
    endfunction

    // predict the result of one accepted word and advance the timer state
    function void note_word(mctd_op_e op, logic [INDEX_W-1:0] idx,
                            logic [DATA_W-1:0] cnt, logic [DATA_W-1:0] per,
                            logic en);
      timer_result_t r;
      r = '0;
      if (op == OP_TICK) begin
        for (int c = 0; c < NUM_CHAN; c++) begin
          if (chan_on[c] && !(chan_count[c] == '0 && chan_period[c] == '0)) begin
            chan_count[c] = chan_count[c] - 1'b1;
            if (chan_count[c] == '0) begin
              chan_count[c] = chan_period[c];
              if (c < MASK_W)
                r.fired[c] = 1'b1;
            end
          end
        end
      end else if (idx >= NUM_CHAN) begin
        r.status = 1'b1;
      end else begin
        case (op)
          OP_SET: begin
            chan_count[idx]  = cnt[CNT_W-1:0];
            chan_period[idx] = per[CNT_W-1:0];
            chan_on[idx]     = en;
          end
          OP_RELOAD: begin
            chan_count[idx] = chan_period[idx];
          end
          default: begin
            if (chan_on[idx]) begin
              chan_on[idx]     = 1'b0;
              chan_count[idx]  = '0;
              chan_period[idx] = '0;
            end
          end
        endcase
      end
      pending_results.push_back(r);
    endfunction

    function void check_word(logic status, logic [MASK_W-1:0] fired);
      timer_result_t exp_r;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, status %0h fired %0h",
                 $time, status, fired);
        fail_count++;
        return;
      end
      exp_r = pending_results.pop_front();
      if (status !== exp_r.status) begin
        $display("%0t: status mismatch, expected %0h actual %0h",
                 $time, exp_r.status, status);
        fail_count++;
      end
      if (fired !== exp_r.fired) begin
        $display("%0t: fired mask mismatch, expected %02h actual %02h",
                 $time, exp_r.fired, fired);
        fail_count++;
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                start          = 1'b0;
  logic                busy;
  logic [OP_W-1:0]     op_i           = '0;
  logic [INDEX_W-1:0]  index_i        = '0;
  logic [DATA_W-1:0]   count_value_i  = '0;
  logic [DATA_W-1:0]   reload_value_i = '0;
  logic                enable_i       = 1'b0;
  logic                done_o;
  logic                status_o;
  logic [MASK_W-1:0]   fired_mask_o;

  tick_scoreboard sb = new();
  bit             gaps_on = 1'b1;
  int             gap_odds = 3;

  multi_channel_tick_dispatcher_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .op_i          (op_i),
    .index_i       (index_i),
    .count_value_i (count_value_i),
    .reload_value_i(reload_value_i),
    .enable_i      (enable_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .fired_mask_o  (fired_mask_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      sb.check_word(status_o, fired_mask_o);
  end

  // present one command word, optionally after an idle burst, and hold it
  // until the block takes it
  task automatic send_word(mctd_op_e op, logic [INDEX_W-1:0] idx,
                           logic [DATA_W-1:0] cnt, logic [DATA_W-1:0] per,
                           logic en);
    if (gaps_on && $urandom_range(0, gap_odds) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    start          <= 1'b1;
    op_i           <= op;
    index_i        <= idx;
    count_value_i  <= cnt;
    reload_value_i <= per;
    enable_i       <= en;
    do @(posedge clk_i); while (busy);
    sb.note_word(op, idx, cnt, per, en);
  endtask

  // mostly small values so channels fire often, with extremes mixed in
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      6:       return '1;
      7:       return '0;
      8, 9:    return $urandom;
      default: return $urandom_range(0, 5);
    endcase
  endfunction

  initial begin
    int         sel;
    mctd_op_e   op;
    logic [7:0] idx;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: one-shot, wrap, reload, extremes, out of range, clears
    send_word(OP_TICK,   8'd0,   32'd0,        32'd0,        1'b0);
    send_word(OP_SET,    8'd0,   32'd1,        32'd0,        1'b1);
    send_word(OP_TICK,   8'd0,   32'd0,        32'd0,        1'b0);
    send_word(OP_TICK,   8'd0,   32'd0,        32'd0,        1'b0);
    send_word(OP_SET,    8'd1,   32'd0,        32'd3,        1'b1);
    send_word(OP_TICK,   8'd0,   32'd0,        32'd0,        1'b0);
    send_word(OP_RELOAD, 8'd1,   32'd0,        32'd0,        1'b0);
    send_word(OP_SET,    8'd7,   32'd2,        32'd2,        1'b1);
    send_word(OP_SET,    8'd2,   32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1);
    send_word(OP_SET,    8'd3,   32'd5,        32'd5,        1'b0);
    send_word(OP_RELOAD, 8'd3,   32'd0,        32'd0,        1'b0);
    send_word(OP_TICK,   8'd0,   32'd0,        32'd0,        1'b0);
    send_word(OP_TICK,   8'd0,   32'd0,        32'd0,        1'b0);
    send_word(OP_TICK,   8'd0,   32'd0,        32'd0,        1'b0);
    send_word(OP_CLEAR,  8'd4,   32'd0,        32'd0,        1'b0);
    send_word(OP_CLEAR,  8'd7,   32'd0,        32'd0,        1'b0);
    send_word(OP_SET,    8'd8,   32'd1,        32'd1,        1'b1);
    send_word(OP_RELOAD, 8'd255, 32'd0,        32'd0,        1'b0);
    send_word(OP_CLEAR,  8'd128, 32'd0,        32'd0,        1'b0);
    send_word(OP_TICK,   8'd255, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1);
    send_word(OP_SET,    8'd5,   32'hFFFFFFFF, 32'd0,        1'b1);
    send_word(OP_SET,    8'd6,   32'd1,        32'd1,        1'b1);
    send_word(OP_TICK,   8'd0,   32'd0,        32'd0,        1'b0);

    for (int i = 0; i < RANDOM_N; i++) begin
      // change idle pressure every hundred words, none at the tail
      if (i % 100 == 0) begin
        gaps_on  = (i < RANDOM_N - CALM_TAIL) && ($urandom_range(0, 3) != 0);
        gap_odds = $urandom_range(1, 6);
      end
      sel = $urandom_range(0, 99);
      if (sel < 50)
        op = OP_TICK;
      else if (sel < 75)
        op = OP_SET;
      else if (sel < 88)
        op = OP_RELOAD;
      else
        op = OP_CLEAR;
      idx = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(8, 255))
                                        : 8'($urandom_range(0, NUM_CHAN - 1));
      send_word(op, idx, pick_value(), pick_value(), $urandom_range(0, 4) != 0);
    end
    start <= 1'b0;

    while (sb.pending() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (sb.fail_count == 0 && sb.pending() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
